>>> hw/rtl/skvt_pkg.sv
// Package for the short key/value table: sizes, operation and status codes,
// and the stored key layout.
// Used by short_key_value_table; depends on nothing.
package skvt_pkg;

   localparam int ENTRIES   = 32;
   localparam int KEY_BYTES = 12;
   localparam int KEY_ROOM  = 12;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int LEN_W     = 4;
   localparam int VAL_W     = 16;

   localparam logic [VAL_W-1:0] NO_VALUE = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_FIND   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_ERASE  = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NOT_FOUND = 3'd1,
      STS_PRESENT   = 3'd2,
      STS_FULL      = 3'd3,
      STS_TOO_LONG  = 3'd4
   } status_type;

   // normalized key: bytes past the effective length are zero
   typedef struct packed {
      logic [LEN_W-1:0]      len;
      logic [8*KEY_ROOM-1:0] bytes;
   } key_type;

endpackage

>>> hw/rtl/short_key_value_table.sv
// Short key/value table: up to ENTRIES keys of up to KEY_BYTES bytes mapped
// to 16-bit values, with find, insert and erase. Depends on skvt_pkg.
//
// Flow: a transaction is accepted in ST_IDLE, then the scan compares the stored
// entries one by one (up to ENTRIES) by the single key comparator on the key
// memory read port, then ST_ERASE_WR writes back for erase, and ST_DONE issues
// the result once the result register is free. A too-long key skips the scan.
// One transaction at a time; the result register lets the next request be
// accepted while the last result waits. Reset empties the table (count zero).
module short_key_value_table
   import skvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[1:0], key_first_bytes[65:2], key_last_bytes[97:66],
   // key_length[101:98], new_value[117:102], zero fill[119:118]
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], found_value[18:3], slot[23:19], entry_count[29:24],
   // zero fill[31:30]
   output logic [31:0]  rsp_tdata
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_SCAN     = 4'b0010,
      ST_ERASE_WR = 4'b0100,
      ST_DONE     = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   key_type                key_ff, key_in;
   mode_type               mode_ff, mode_in;
   logic [VAL_W-1:0]       nv_ff, nv_in;
   status_type             status_ff, status_in;
   logic [VAL_W-1:0]       value_ff, value_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_data_ff, rsp_data_in;

   key_type                key_mem_ff [ENTRIES];
   logic [VAL_W-1:0]       val_mem_ff [ENTRIES];
   key_type                rd_key_ff;
   logic [VAL_W-1:0]       rd_val_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   key_type                wr_key;
   logic [VAL_W-1:0]       wr_val;

   key_type                req_key;
   logic [LEN_W-1:0]       req_len;
   logic                   hit;
   logic                   last_entry;
   logic                   fin_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_len    = req_tdata[101:98];

   // Cut the key at its length or its first zero byte.
   always_comb begin
      logic          cut;
      logic [7:0]    b;
      logic [95:0]   raw;
      raw     = {req_tdata[97:66], req_tdata[65:2]};
      cut     = 1'b0;
      req_key = '0;
      for (int i = 0; i < KEY_ROOM; i++) begin
         b = raw[8*i +: 8];
         if ((LEN_W'(i) >= req_len) || (b == 8'd0)) begin
            cut = 1'b1;
         end
         if (!cut) begin
            req_key.bytes[8*i +: 8] = b;
            req_key.len             = LEN_W'(i + 1);
         end
      end
   end

   assign hit        = (CNT_W'(idx_ff) < count_ff) && (rd_key_ff == key_ff);
   assign last_entry = (CNT_W'(idx_ff) + CNT_W'(1)) >= count_ff;
   assign fin_ok     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      mode_in      = mode_ff;
      nv_in        = nv_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_key       = key_ff;
      wr_val       = nv_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in   = mode_type'(req_tdata[1:0]);
               key_in    = req_key;
               nv_in     = req_tdata[117:102];
               status_in = STS_OK;
               value_in  = NO_VALUE;
               slot_in   = '0;
               idx_in    = '0;
               if (req_len > LEN_W'(KEY_BYTES)) begin
                  status_in = STS_TOO_LONG;
                  state_in  = ST_DONE;
               end else begin
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff + IDX_W'(1);
            if (hit) begin
               state_in = ST_DONE;
               case (mode_ff)
                  MODE_INSERT: begin
                     status_in = STS_PRESENT;
                  end
                  MODE_ERASE: begin
                     slot_in  = idx_ff;
                     value_in = rd_val_ff;
                     // fetch the last entry to fill the vacated slot
                     rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                     state_in = ST_ERASE_WR;
                  end
                  default: begin
                     slot_in  = idx_ff;
                     value_in = rd_val_ff;
                  end
               endcase
            end else if (last_entry) begin
               state_in = ST_DONE;
               if (mode_ff == MODE_INSERT) begin
                  if (count_ff >= CNT_W'(ENTRIES)) begin
                     status_in = STS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = IDX_W'(count_ff);
                     value_in = nv_ff;
                     slot_in  = IDX_W'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  status_in = STS_NOT_FOUND;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_ERASE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_key   = rd_key_ff;
            wr_val   = rd_val_ff;
            count_in = count_ff - CNT_W'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (fin_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, 6'(count_ff), 5'(slot_ff), value_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      key_ff      <= key_in;
      mode_ff     <= mode_in;
      nv_ff       <= nv_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   // key and value memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_key;
         val_mem_ff[wr_addr] <= wr_val;
      end
      rd_key_ff <= key_mem_ff[rd_addr];
      rd_val_ff <= val_mem_ff[rd_addr];
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above table depth");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + CNT_W'(1)) ||
          (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("entry count moved by more than one");

   a_fail_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[2:0] != STS_OK)) |->
         ((rsp_data_ff[18:3] == NO_VALUE) && (rsp_data_ff[23:19] == 5'd0)))
      else $error("failed result carries a value or slot");

   a_busy_no_accept : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (req_tready == (state_ff == ST_IDLE)) && !$rose(rsp_valid_ff))
      else $error("result raised straight out of the scan");

endmodule
